/* rtl/core/lebu_pkg.sv */
// Shared request codes, field widths and control structs of the line edit buffer.
package lebu_pkg;

   localparam int REQ_W  = 3;
   localparam int CHAR_W = 8;
   localparam int POS_W  = 9;
   localparam int OUT_W  = 8;

   localparam logic [REQ_W-1:0] REQ_APPEND    = 3'd0;
   localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd1;
   localparam logic [REQ_W-1:0] REQ_OVERWRITE = 3'd2;
   localparam logic [REQ_W-1:0] REQ_DELETE    = 3'd3;
   localparam logic [REQ_W-1:0] REQ_COMMIT    = 3'd4;
   localparam logic [REQ_W-1:0] REQ_RESTORE   = 3'd5;
   localparam logic [REQ_W-1:0] REQ_READ      = 3'd6;

   // command into the copy sequencer
   typedef struct packed {
      logic go;
      logic down;
   } copy_cmd_type;

   // status out of the copy sequencer
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic done;
   } copy_sts_type;

endpackage

/* rtl/core/lebu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lebu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/lebu_copy.sv */
// Copy sequencer: moves one word per cycle from a source to a destination address range.
module lebu_copy import lebu_pkg::*; #(
   parameter int AW = 7,
   parameter int LW = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  copy_cmd_type cmd,
   input  logic [AW-1:0] src_addr,
   input  logic [AW-1:0] dst_addr,
   input  logic [LW-1:0] count,
   output copy_sts_type sts,
   output logic [AW-1:0] rd_addr,
   output logic [AW-1:0] wr_addr
);

   logic          run_ff, run_in;
   logic          down_ff, down_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic [AW-1:0] src_ff, src_in;
   logic [AW-1:0] dst_ff, dst_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic          step;

   assign step = run_ff && (rem_ff != '0);

   always_comb begin
      run_in       = run_ff;
      down_in      = down_ff;
      rem_in       = rem_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      if (cmd.go) begin
         run_in  = 1'b1;
         down_in = cmd.down;
         rem_in  = count;
         src_in  = src_addr;
         dst_in  = dst_addr;
      end else begin
         if (step) begin
            // read now, write the same word in the next cycle
            pend_in      = 1'b1;
            pend_addr_in = dst_ff;
            rem_in       = rem_ff - LW'(1);
            src_in       = down_ff ? src_ff - AW'(1) : src_ff + AW'(1);
            dst_in       = down_ff ? dst_ff - AW'(1) : dst_ff + AW'(1);
         end
         if (sts.done) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         pend_ff <= 1'b0;
         rem_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         pend_ff <= pend_in;
         rem_ff  <= rem_in;
      end
      down_ff      <= down_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      pend_addr_ff <= pend_addr_in;
   end

   assign sts.rd_en = step;
   assign sts.wr_en = pend_ff;
   assign sts.done  = run_ff && (rem_ff == '0) && !pend_ff;
   assign rd_addr   = src_ff;
   assign wr_addr   = pend_addr_ff;

endmodule

/* rtl/core/line_edit_buffer_with_undo.sv */
// Top level of the line edit buffer with one level of undo.
//
// A request is taken when start is high and busy is low; busy then stays high until the
// cycle after its single result, which shows on the rsp_ ports for one cycle with rsp_valid
// and must be captured then, as the block cannot be held off. Characters live in a line RAM
// and a snapshot RAM, and one copy sequencer moves one word per cycle between or within them,
// so the cost of a request follows the number of characters it moves. Commit, a rejected
// request and a restore without a snapshot go straight to the result; read steps through
// S_READ and S_READ_DATA, and append and overwrite through S_EDIT and S_WRITE. Insert
// first shifts the tail of the line right by one, and delete works out its range and then
// shifts the tail left over it; either shift is empty when it reaches the end of the line.
// The first edit after a commit or restore on a non-empty line first copies the whole line
// into the snapshot. Restore copies the snapshot back into the line. No clearing pass runs
// after reset.
module line_edit_buffer_with_undo import lebu_pkg::*; #(
   parameter int LINE_SIZE = 128
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [REQ_W-1:0]        req_type,
   input  logic [CHAR_W-1:0]       req_char_in,
   input  logic signed [POS_W-1:0] req_position,
   input  logic signed [POS_W-1:0] req_del_count,
   output logic                    rsp_valid,
   output logic                    rsp_status,
   output logic [OUT_W-1:0]        rsp_start_index,
   output logic [OUT_W-1:0]        rsp_length,
   output logic [CHAR_W-1:0]       rsp_char_out
);

   localparam int AW = $clog2(LINE_SIZE);
   localparam int LW = $clog2(LINE_SIZE + 1);
   localparam int SW = ((LW > POS_W) ? LW : POS_W) + 2;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DEL_BASE  = 4'd1;
   localparam logic [3:0] S_DEL_CLAMP = 4'd2;
   localparam logic [3:0] S_DEL_RANGE = 4'd3;
   localparam logic [3:0] S_SNAP_GO   = 4'd4;
   localparam logic [3:0] S_SNAP_RUN  = 4'd5;
   localparam logic [3:0] S_EDIT      = 4'd6;
   localparam logic [3:0] S_SHIFT_RUN = 4'd7;
   localparam logic [3:0] S_WRITE     = 4'd8;
   localparam logic [3:0] S_REST_GO   = 4'd9;
   localparam logic [3:0] S_REST_RUN  = 4'd10;
   localparam logic [3:0] S_READ      = 4'd11;
   localparam logic [3:0] S_READ_DATA = 4'd12;
   localparam logic [3:0] S_RESP      = 4'd13;

   // clamp a signed value to 0..lim
   function automatic logic [LW-1:0] clamp_len(input logic signed [SW-1:0] v,
                                                input logic signed [SW-1:0] lim);
      logic [LW-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > lim) begin
         r = LW'(lim);
      end else begin
         r = LW'(v);
      end
      return r;
   endfunction

   // sequencer and request registers
   logic [3:0]              state_ff, state_in;
   logic [REQ_W-1:0]        op_ff, op_in;
   logic [CHAR_W-1:0]       ch_ff, ch_in;
   logic signed [POS_W-1:0] pos_ff, pos_in;
   logic signed [POS_W-1:0] cnt_ff, cnt_in;
   logic                    status_ff, status_in;
   logic [LW-1:0]           start_ff, start_in;
   logic [CHAR_W-1:0]       char_ff, char_in;
   logic signed [SW-1:0]    a0_ff, a0_in;
   logic [LW-1:0]           lo_ff, lo_in;
   logic [LW-1:0]           hi_ff, hi_in;
   logic [AW-1:0]           wr_addr_ff, wr_addr_in;

   // architectural state
   logic [LW-1:0]           len_ff, len_in;
   logic [LW-1:0]           snap_len_ff, snap_len_in;
   logic                    snap_valid_ff, snap_valid_in;

   // request decode
   logic                    accept;
   logic                    full;
   logic                    snap_needed;
   logic                    ok;
   logic signed [SW-1:0]    len_w;
   logic signed [SW-1:0]    req_pos_w;
   logic signed [SW-1:0]    pos_w;
   logic signed [SW-1:0]    cnt_w;

   // copy sequencer hookup
   copy_cmd_type            copy_cmd;
   copy_sts_type            copy_sts;
   logic [AW-1:0]           copy_src;
   logic [AW-1:0]           copy_dst;
   logic [LW-1:0]           copy_count;
   logic [AW-1:0]           copy_rd_addr;
   logic [AW-1:0]           copy_wr_addr;

   // RAM ports
   logic                    line_wr_en, line_rd_en;
   logic [AW-1:0]           line_wr_addr, line_rd_addr;
   logic [CHAR_W-1:0]       line_wr_data, line_rd_data;
   logic                    snap_wr_en, snap_rd_en;
   logic [AW-1:0]           snap_wr_addr, snap_rd_addr;
   logic [CHAR_W-1:0]       snap_wr_data, snap_rd_data;

   assign busy        = (state_ff != S_IDLE);
   assign accept      = start && !busy;
   assign len_w       = signed'(SW'(len_ff));
   assign req_pos_w   = SW'(req_position);
   assign pos_w       = SW'(pos_ff);
   assign cnt_w       = SW'(cnt_ff);
   assign full        = (len_ff == LW'(LINE_SIZE));
   assign snap_needed = !snap_valid_ff && (len_ff != '0);

   // accept or reject against the length at the time of the request
   always_comb begin
      unique case (req_type)
         REQ_APPEND:    ok = !full;
         REQ_INSERT:    ok = !full && (req_pos_w >= 0) && (req_pos_w <= len_w);
         REQ_OVERWRITE: ok = (req_pos_w >= 0) && (req_pos_w < len_w);
         REQ_DELETE:    ok = (len_ff != '0) && (req_del_count != '0);
         REQ_COMMIT:    ok = 1'b1;
         REQ_RESTORE:   ok = 1'b1;
         REQ_READ:      ok = (req_pos_w >= 0) && (req_pos_w < len_w);
         default:       ok = 1'b0;
      endcase
   end

   // copy commands: snapshot, restore, right shift for insert, left shift for delete
   always_comb begin
      copy_cmd   = '0;
      copy_src   = '0;
      copy_dst   = '0;
      copy_count = len_ff;
      unique case (state_ff)
         S_SNAP_GO: begin
            copy_cmd.go = 1'b1;
         end
         S_REST_GO: begin
            copy_cmd.go = 1'b1;
            copy_count  = snap_len_ff;
         end
         S_EDIT: begin
            if (op_ff == REQ_INSERT) begin
               copy_cmd.go   = 1'b1;
               copy_cmd.down = 1'b1;
               copy_src      = AW'(len_ff - LW'(1));
               copy_dst      = AW'(len_ff);
               copy_count    = LW'(len_w - pos_w);
            end else if (op_ff == REQ_DELETE) begin
               copy_cmd.go = 1'b1;
               copy_src    = AW'(hi_ff);
               copy_dst    = AW'(lo_ff);
               copy_count  = len_ff - hi_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // steer the RAM ports by sequencer state
   always_comb begin
      line_wr_en   = 1'b0;
      line_wr_addr = copy_wr_addr;
      line_wr_data = line_rd_data;
      line_rd_en   = 1'b0;
      line_rd_addr = copy_rd_addr;
      snap_wr_en   = 1'b0;
      snap_wr_addr = copy_wr_addr;
      snap_wr_data = line_rd_data;
      snap_rd_en   = 1'b0;
      snap_rd_addr = copy_rd_addr;
      unique case (state_ff)
         S_SNAP_RUN: begin
            line_rd_en = copy_sts.rd_en;
            snap_wr_en = copy_sts.wr_en;
         end
         S_SHIFT_RUN: begin
            line_rd_en = copy_sts.rd_en;
            line_wr_en = copy_sts.wr_en;
         end
         S_REST_RUN: begin
            snap_rd_en   = copy_sts.rd_en;
            line_wr_en   = copy_sts.wr_en;
            line_wr_data = snap_rd_data;
         end
         S_WRITE: begin
            line_wr_en   = 1'b1;
            line_wr_addr = wr_addr_ff;
            line_wr_data = ch_ff;
         end
         S_READ: begin
            line_rd_en   = 1'b1;
            line_rd_addr = AW'(pos_ff);
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      ch_in         = ch_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      status_in     = status_ff;
      start_in      = start_ff;
      char_in       = char_ff;
      a0_in         = a0_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      wr_addr_in    = wr_addr_ff;
      len_in        = len_ff;
      snap_len_in   = snap_len_ff;
      snap_valid_in = snap_valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_type;
               ch_in     = req_char_in;
               pos_in    = req_position;
               cnt_in    = req_del_count;
               status_in = !ok;
               start_in  = '0;
               char_in   = '0;
               if (!ok) begin
                  state_in = S_RESP;
               end else begin
                  unique case (req_type)
                     REQ_APPEND, REQ_INSERT, REQ_OVERWRITE: begin
                        state_in = snap_needed ? S_SNAP_GO : S_EDIT;
                     end
                     REQ_DELETE: begin
                        state_in = S_DEL_BASE;
                     end
                     REQ_COMMIT: begin
                        snap_valid_in = 1'b0;
                        state_in      = S_RESP;
                     end
                     REQ_RESTORE: begin
                        state_in = snap_valid_ff ? S_REST_GO : S_RESP;
                     end
                     REQ_READ: begin
                        state_in = S_READ;
                     end
                     default: begin
                        state_in = S_RESP;
                     end
                  endcase
               end
            end
         end
         S_DEL_BASE: begin
            // a negative position counts from the end
            a0_in    = (pos_w < 0) ? pos_w + len_w : pos_w;
            state_in = S_DEL_CLAMP;
         end
         S_DEL_CLAMP: begin
            lo_in    = clamp_len(a0_ff, len_w);
            hi_in    = clamp_len(a0_ff + cnt_w, len_w);
            state_in = S_DEL_RANGE;
         end
         S_DEL_RANGE: begin
            // order the ends so a backward count works like a forward one
            if (hi_ff < lo_ff) begin
               lo_in = hi_ff;
               hi_in = lo_ff;
            end
            start_in = (hi_ff < lo_ff) ? hi_ff : lo_ff;
            state_in = snap_needed ? S_SNAP_GO : S_EDIT;
         end
         S_SNAP_GO: begin
            state_in = S_SNAP_RUN;
         end
         S_SNAP_RUN: begin
            if (copy_sts.done) begin
               snap_valid_in = 1'b1;
               snap_len_in   = len_ff;
               state_in      = S_EDIT;
            end
         end
         S_EDIT: begin
            unique case (op_ff)
               REQ_APPEND: begin
                  wr_addr_in = AW'(len_ff);
                  state_in   = S_WRITE;
               end
               REQ_OVERWRITE: begin
                  wr_addr_in = AW'(pos_ff);
                  state_in   = S_WRITE;
               end
               REQ_INSERT: begin
                  wr_addr_in = AW'(pos_ff);
                  state_in   = S_SHIFT_RUN;
               end
               default: begin
                  state_in = S_SHIFT_RUN;
               end
            endcase
         end
         S_SHIFT_RUN: begin
            if (copy_sts.done) begin
               if (op_ff == REQ_DELETE) begin
                  len_in   = len_ff - (hi_ff - lo_ff);
                  state_in = S_RESP;
               end else begin
                  state_in = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            if (op_ff != REQ_OVERWRITE) begin
               len_in = len_ff + LW'(1);
            end
            state_in = S_RESP;
         end
         S_REST_GO: begin
            state_in = S_REST_RUN;
         end
         S_REST_RUN: begin
            if (copy_sts.done) begin
               len_in        = snap_len_ff;
               snap_valid_in = 1'b0;
               state_in      = S_RESP;
            end
         end
         S_READ: begin
            state_in = S_READ_DATA;
         end
         S_READ_DATA: begin
            char_in  = line_rd_data;
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         len_ff        <= '0;
         snap_len_ff   <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         snap_len_ff   <= snap_len_in;
         snap_valid_ff <= snap_valid_in;
      end
      op_ff      <= op_in;
      ch_ff      <= ch_in;
      pos_ff     <= pos_in;
      cnt_ff     <= cnt_in;
      status_ff  <= status_in;
      start_ff   <= start_in;
      char_ff    <= char_in;
      a0_ff      <= a0_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      wr_addr_ff <= wr_addr_in;
   end

   lebu_copy #(
      .AW(AW),
      .LW(LW)
   ) u_copy (
      .clock   (clock),
      .reset   (reset),
      .cmd     (copy_cmd),
      .src_addr(copy_src),
      .dst_addr(copy_dst),
      .count   (copy_count),
      .sts     (copy_sts),
      .rd_addr (copy_rd_addr),
      .wr_addr (copy_wr_addr)
   );

   lebu_ram #(
      .WIDTH(CHAR_W),
      .DEPTH(LINE_SIZE)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (line_wr_en),
      .wr_addr(line_wr_addr),
      .wr_data(line_wr_data),
      .rd_en  (line_rd_en),
      .rd_addr(line_rd_addr),
      .rd_data(line_rd_data)
   );

   lebu_ram #(
      .WIDTH(CHAR_W),
      .DEPTH(LINE_SIZE)
   ) u_snap_ram (
      .clock  (clock),
      .wr_en  (snap_wr_en),
      .wr_addr(snap_wr_addr),
      .wr_data(snap_wr_data),
      .rd_en  (snap_rd_en),
      .rd_addr(snap_rd_addr),
      .rd_data(snap_rd_data)
   );

   // one result word per request, shown for a single cycle
   assign rsp_valid       = (state_ff == S_RESP);
   assign rsp_status      = status_ff;
   assign rsp_start_index = OUT_W'(start_ff);
   assign rsp_length      = OUT_W'(len_ff);
   assign rsp_char_out    = char_ff;

   // hold busy from the accepting edge on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after an accepted request");

   // drop busy only right after the result word
   a_busy_ends_at_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(rsp_valid))
      else $error("busy fell without a result word");

   // keep the line length within the RAM
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (len_ff <= LW'(LINE_SIZE)) && (snap_len_ff <= LW'(LINE_SIZE)))
      else $error("line or snapshot length beyond LINE_SIZE");

   // never write either RAM while idle
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (!line_wr_en && !snap_wr_en))
      else $error("RAM write while idle");

endmodule
